FILE: rtl/dmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants, field widths and control types for the direct-mapped
// cache lookup block.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Geometry
  localparam int NUM_SETS    = 16;
  localparam int SET_FIELD_W = 4;
  localparam int SET_SPAN    = 1 << SET_FIELD_W;
  // Only sets that the 4-bit index field can reach get storage
  localparam int NUM_USED    = (NUM_SETS < SET_SPAN) ? NUM_SETS : SET_SPAN;
  localparam int IDX_W       = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 2;
  localparam int TAG_LSB  = 6;
  localparam int TAG_W    = ADDR_W - TAG_LSB;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Request codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Lookup status codes
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COLD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;

  // Byte offset codes
  localparam logic [OFFSET_W-1:0] OFF_B0 = 2'd0;
  localparam logic [OFFSET_W-1:0] OFF_B1 = 2'd1;
  localparam logic [OFFSET_W-1:0] OFF_B2 = 2'd2;
  localparam logic [OFFSET_W-1:0] OFF_B3 = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch request and read the stores
    logic commit;   // load the result register and update the stores
  } dmc_cmd_t;

endpackage

FILE: rtl/direct_mapped_cache_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup_top
// Direct-mapped cache of 4-byte lines: reads report hit, cold or conflict
// miss; writes replace the line and report any eviction.
// ----------------------------------------------------------------------------
// In each access the accept edge reads the valid, tag and data stores into
// registers, and the commit edge compares tags, loads the result register
// and writes the line. A new beat is taken once that commit is done, while
// the previous result may still wait on out_stall. A commit waits only
// when the result register still holds an untaken beat. Valid bits clear
// at reset with no clearing pass; sets whose index is not below the
// configured set count read as cold misses and drop writes.
// ----------------------------------------------------------------------------
module direct_mapped_cache_lookup_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [dmc_pkg::ADDR_W-1:0]   in_address,
  input  logic [dmc_pkg::DATA_W-1:0]   in_write_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dmc_pkg::STATUS_W-1:0] out_lookup_status,
  output logic                         out_line_was_valid,
  output logic [dmc_pkg::TAG_W-1:0]    out_stored_tag,
  output logic [dmc_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                         out_evicted,
  output logic [dmc_pkg::DATA_W-1:0]   out_evicted_data
);

  dmc_pkg::dmc_cmd_t cmd;

  // Sequence the access
  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Look up and update the stores
  dmc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .out_lookup_status  (out_lookup_status),
    .out_line_was_valid (out_line_was_valid),
    .out_stored_tag     (out_stored_tag),
    .out_read_byte      (out_read_byte),
    .out_evicted        (out_evicted),
    .out_evicted_data   (out_evicted_data)
  );

endmodule

FILE: rtl/dmc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer for one access: accept a beat, wait for the store read, then
// commit the result once the output register is free.
// ----------------------------------------------------------------------------
module dmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output dmc_pkg::dmc_cmd_t cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // Output register can take a new beat
  assign out_free = !out_valid_r || !out_stall;

  // Decode commands and next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/dmc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_datapath
// Valid bits, tag and data stores, tag compare, byte select and the result
// register.
// ----------------------------------------------------------------------------
module dmc_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dmc_pkg::dmc_cmd_t                cmd,
  input  logic                             in_req_type,
  input  logic [dmc_pkg::ADDR_W-1:0]       in_address,
  input  logic [dmc_pkg::DATA_W-1:0]       in_write_data,
  output logic [dmc_pkg::STATUS_W-1:0]     out_lookup_status,
  output logic                             out_line_was_valid,
  output logic [dmc_pkg::TAG_W-1:0]        out_stored_tag,
  output logic [dmc_pkg::BYTE_W-1:0]       out_read_byte,
  output logic                             out_evicted,
  output logic [dmc_pkg::DATA_W-1:0]       out_evicted_data
);

  // Stores
  logic [dmc_pkg::NUM_USED-1:0] valid_r;
  logic [dmc_pkg::TAG_W-1:0]    tag_mem  [dmc_pkg::NUM_USED];
  logic [dmc_pkg::DATA_W-1:0]   data_mem [dmc_pkg::NUM_USED];

  // Captured request
  logic                            req_r;
  logic [dmc_pkg::OFFSET_W-1:0]    off_r;
  logic [dmc_pkg::IDX_W-1:0]       idx_r;
  logic                            in_range_r;
  logic [dmc_pkg::TAG_W-1:0]       tag_r;
  logic [dmc_pkg::DATA_W-1:0]      wdata_r;
  logic                            hit_valid_r;
  logic [dmc_pkg::TAG_W-1:0]       tag_rd_r;
  logic [dmc_pkg::DATA_W-1:0]      data_rd_r;

  // Result register
  logic [dmc_pkg::STATUS_W-1:0] status_r;
  logic [dmc_pkg::STATUS_W-1:0] status_nxt;
  logic                         was_valid_r;
  logic [dmc_pkg::TAG_W-1:0]    old_tag_r;
  logic [dmc_pkg::TAG_W-1:0]    old_tag_nxt;
  logic [dmc_pkg::BYTE_W-1:0]   rbyte_r;
  logic [dmc_pkg::BYTE_W-1:0]   rbyte_nxt;
  logic                         ev_r;
  logic                         ev_nxt;
  logic [dmc_pkg::DATA_W-1:0]   evdata_r;
  logic [dmc_pkg::DATA_W-1:0]   evdata_nxt;

  // Address split of the incoming beat
  logic [dmc_pkg::SET_FIELD_W-1:0] in_set;
  logic [dmc_pkg::IDX_W-1:0]       in_idx;
  logic                            in_range;
  logic [dmc_pkg::BYTE_W-1:0]      sel_byte;
  logic                            tag_match;

  assign in_set   = in_address[dmc_pkg::OFFSET_W +: dmc_pkg::SET_FIELD_W];
  assign in_idx   = in_set[dmc_pkg::IDX_W-1:0];
  assign in_range = ({1'b0, in_set} < (dmc_pkg::SET_FIELD_W + 1)'(dmc_pkg::NUM_USED));

  // Capture the request and read the stores
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r       <= in_req_type;
      off_r       <= in_address[dmc_pkg::OFFSET_W-1:0];
      idx_r       <= in_idx;
      in_range_r  <= in_range;
      tag_r       <= in_address[dmc_pkg::ADDR_W-1:dmc_pkg::TAG_LSB];
      wdata_r     <= in_write_data;
      hit_valid_r <= in_range && valid_r[in_idx];
      tag_rd_r    <= tag_mem[in_idx];
      data_rd_r   <= data_mem[in_idx];
    end
  end

  // Select the addressed byte, low byte first
  always_comb begin
    case (off_r)
      dmc_pkg::OFF_B0: sel_byte = data_rd_r[7:0];
      dmc_pkg::OFF_B1: sel_byte = data_rd_r[15:8];
      dmc_pkg::OFF_B2: sel_byte = data_rd_r[23:16];
      dmc_pkg::OFF_B3: sel_byte = data_rd_r[31:24];
      default:         sel_byte = data_rd_r[7:0];
    endcase
  end

  assign tag_match = (tag_rd_r == tag_r);

  // Build the result
  always_comb begin
    status_nxt  = dmc_pkg::ST_HIT;
    old_tag_nxt = hit_valid_r ? tag_rd_r : '0;
    rbyte_nxt   = '0;
    ev_nxt      = 1'b0;
    evdata_nxt  = '0;
    if (req_r == dmc_pkg::REQ_READ) begin
      if (!hit_valid_r) begin
        status_nxt = dmc_pkg::ST_COLD;
      end else begin
        status_nxt = tag_match ? dmc_pkg::ST_HIT : dmc_pkg::ST_CONFLICT;
        rbyte_nxt  = sel_byte;
      end
    end else if (hit_valid_r && !tag_match) begin
      ev_nxt     = 1'b1;
      evdata_nxt = data_rd_r;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r    <= status_nxt;
      was_valid_r <= hit_valid_r;
      old_tag_r   <= old_tag_nxt;
      rbyte_r     <= rbyte_nxt;
      ev_r        <= ev_nxt;
      evdata_r    <= evdata_nxt;
    end
  end

  // Write the line on commit; out-of-range sets drop the write
  always_ff @(posedge clk) begin
    if (cmd.commit && (req_r == dmc_pkg::REQ_WRITE) && in_range_r) begin
      tag_mem[idx_r]  <= tag_r;
      data_mem[idx_r] <= wdata_r;
    end
  end

  // Hold the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && (req_r == dmc_pkg::REQ_WRITE) && in_range_r) begin
      valid_r[idx_r] <= 1'b1;
    end
  end

  assign out_lookup_status  = status_r;
  assign out_line_was_valid = was_valid_r;
  assign out_stored_tag     = old_tag_r;
  assign out_read_byte      = rbyte_r;
  assign out_evicted        = ev_r;
  assign out_evicted_data   = evdata_r;

endmodule
